// ----- hdl/clts_pkg.sv -----
// Shared types and constants for the character LCD text sequencer.
package clts_pkg;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 8;
    localparam int ROWS_W  = 3;
    localparam int CNT_W   = 14;
    localparam int CFG_W   = 6;

    // shift-right instructions per display row
    localparam int ROW_STRIDE = 40;

    localparam logic [COL_W-1:0]  COLUMNS_RST = 6'd16;
    localparam logic [ROWS_W-1:0] ROWS_RST    = 3'd2;

    // front-to-back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // input commands
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // HD44780 instruction bytes
    localparam logic [7:0] OP_MODE_NIBBLE  = 8'h02;
    localparam logic [7:0] OP_FUNCTION_SET = 8'h28;
    localparam logic [7:0] OP_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] OP_CLEAR        = 8'h01;
    localparam logic [7:0] OP_HOME         = 8'h02;
    localparam logic [7:0] OP_SHIFT_RIGHT  = 8'h14;

    typedef enum logic [1:0] {
        K_INIT,
        K_BEGIN,
        K_LINE
    } t_kind;

    // one classified item waiting for the back end
    typedef struct packed {
        t_kind             kind;
        logic              has_data;
        logic              has_row;
        logic [7:0]        char_byte;
        logic [CNT_W-1:0]  shifts;
    } t_job;

endpackage

// ----- hdl/clts_ifs.sv -----
// Valid/ready channel interfaces for text items and bus results.
interface clts_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_code;

    modport source (output valid, output cmd, output char_code, input ready);
    modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

interface clts_res_if;
    logic                      valid;
    logic                      ready;
    logic                      reg_select;
    logic [7:0]                bus_byte;
    logic [clts_pkg::CNT_W-1:0] repeat_count;
    logic                      nibble_only;
    logic                      last;

    modport source (output valid, output reg_select, output bus_byte,
                    output repeat_count, output nibble_only, output last,
                    input ready);
    modport sink   (input valid, input reg_select, input bus_byte,
                    input repeat_count, input nibble_only, input last,
                    output ready);
endinterface

// ----- hdl/clts_front.sv -----
// Front end: takes items, tracks the cursor and classifies each item into a job.
module clts_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    clts_item_if.sink              i_item,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [clts_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                   i_full,
    output logic                   o_push,
    output clts_pkg::t_job         o_job
);

    logic [clts_pkg::COL_W-1:0]  r_columns;
    logic [clts_pkg::ROWS_W-1:0] r_rows;
    logic [clts_pkg::COL_W-1:0]  r_col, n_col;
    logic [clts_pkg::ROW_W-1:0]  r_row, n_row;

    logic                        accept;
    logic [clts_pkg::ROW_W-1:0]  row_inc;
    logic [clts_pkg::COL_W:0]    next_col;
    logic [clts_pkg::CNT_W-1:0]  shifts_inc;

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;

    assign row_inc    = (r_row == '1) ? r_row : r_row + 1'b1;
    assign next_col   = {1'b0, r_col} + 1'b1;
    assign shifts_inc = clts_pkg::CNT_W'(clts_pkg::ROW_STRIDE)
                        * clts_pkg::CNT_W'(row_inc);

    always_comb begin
        n_col            = r_col;
        n_row            = r_row;
        o_push           = 1'b0;
        o_job.kind       = clts_pkg::K_LINE;
        o_job.has_data   = 1'b0;
        o_job.has_row    = 1'b0;
        o_job.char_byte  = i_item.char_code;
        o_job.shifts     = shifts_inc;
        if (accept) begin
            case (i_item.cmd)
                clts_pkg::CMD_INIT: begin
                    o_push     = 1'b1;
                    o_job.kind = clts_pkg::K_INIT;
                    n_col      = '0;
                    n_row      = '0;
                end
                clts_pkg::CMD_BEGIN: begin
                    o_push     = 1'b1;
                    o_job.kind = clts_pkg::K_BEGIN;
                    n_col      = '0;
                    n_row      = '0;
                end
                clts_pkg::CMD_CHAR: begin
                    if (i_item.char_code == clts_pkg::CH_NEWLINE) begin
                        o_push        = 1'b1;
                        o_job.has_row = 1'b1;
                        n_row         = row_inc;
                        n_col         = '0;
                    end else if (r_row < clts_pkg::ROW_W'(r_rows)) begin
                        o_push         = 1'b1;
                        o_job.has_data = 1'b1;
                        if (next_col >= {1'b0, r_columns}) begin
                            o_job.has_row = 1'b1;
                            n_row         = row_inc;
                            n_col         = '0;
                        end else begin
                            n_col = next_col[clts_pkg::COL_W-1:0];
                        end
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= clts_pkg::COLUMNS_RST;
            r_rows    <= clts_pkg::ROWS_RST;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                if (i_cfg_idx == clts_pkg::CFG_COLUMNS) begin
                    r_columns <= i_cfg_data[clts_pkg::COL_W-1:0];
                end else begin
                    r_rows <= i_cfg_data[clts_pkg::ROWS_W-1:0];
                end
            end
        end
    end

endmodule

// ----- hdl/clts_queue.sv -----
// Short job queue between front and back ends.
module clts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clts_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_avail,
    output clts_pkg::t_job  o_job
);

    clts_pkg::t_job                r_mem [clts_pkg::QDEPTH];
    logic [clts_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [clts_pkg::QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (clts_pkg::QPTR_W+1)'(clts_pkg::QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (clts_pkg::QPTR_W+1)'(clts_pkg::QDEPTH))
        else $error("job queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("job queue popped while empty");

endmodule

// ----- hdl/clts_back.sv -----
// Back end: expands each queued job into its bus results, one per cycle while o_res.ready is high.
module clts_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  clts_pkg::t_job  i_job,
    output logic            o_pop,
    clts_res_if.source      o_res
);

    logic [2:0]                  r_step;
    logic [2:0]                  eff_step;
    logic                        load;

    logic                        r_valid;
    logic                        r_rs;
    logic [7:0]                  r_byte;
    logic [clts_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_nib;
    logic                        r_last;

    logic                        c_rs;
    logic [7:0]                  c_byte;
    logic [clts_pkg::CNT_W-1:0]  c_cnt;
    logic                        c_nib;
    logic                        c_last;

    // a line job without data starts at the home instruction
    assign eff_step = (i_job.kind == clts_pkg::K_LINE && r_step == 3'd0 && !i_job.has_data)
                      ? 3'd1 : r_step;

    always_comb begin
        c_rs   = 1'b0;
        c_byte = clts_pkg::OP_HOME;
        c_cnt  = clts_pkg::CNT_W'(1);
        c_nib  = 1'b0;
        c_last = 1'b1;
        case (i_job.kind)
            clts_pkg::K_INIT: begin
                c_last = (eff_step == 3'd4);
                case (eff_step)
                    3'd0: begin
                        c_byte = clts_pkg::OP_MODE_NIBBLE;
                        c_nib  = 1'b1;
                    end
                    3'd1:    c_byte = clts_pkg::OP_FUNCTION_SET;
                    3'd2:    c_byte = clts_pkg::OP_DISPLAY_ON;
                    3'd3:    c_byte = clts_pkg::OP_CLEAR;
                    default: c_byte = clts_pkg::OP_HOME;
                endcase
            end
            clts_pkg::K_BEGIN: begin
                c_last = (eff_step == 3'd1);
                c_byte = (eff_step == 3'd0) ? clts_pkg::OP_CLEAR : clts_pkg::OP_HOME;
            end
            clts_pkg::K_LINE: begin
                case (eff_step)
                    3'd0: begin
                        c_rs   = 1'b1;
                        c_byte = i_job.char_byte;
                        c_last = !i_job.has_row;
                    end
                    3'd1: begin
                        c_byte = clts_pkg::OP_HOME;
                        c_last = (i_job.shifts == '0);
                    end
                    default: begin
                        c_byte = clts_pkg::OP_SHIFT_RIGHT;
                        c_cnt  = i_job.shifts;
                    end
                endcase
            end
            default: begin
                c_last = 1'b1;
            end
        endcase
    end

    assign load  = i_avail && (!r_valid || o_res.ready);
    assign o_pop = load && c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= c_last ? 3'd0 : eff_step + 3'd1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs   <= c_rs;
            r_byte <= c_byte;
            r_cnt  <= c_cnt;
            r_nib  <= c_nib;
            r_last <= c_last;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.reg_select   = r_rs;
    assign o_res.bus_byte     = r_byte;
    assign o_res.repeat_count = r_cnt;
    assign o_res.nibble_only  = r_nib;
    assign o_res.last         = r_last;

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != '0))
        else $error("result with zero repeat count");

    a_data_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rs) |-> (r_cnt == clts_pkg::CNT_W'(1) && !r_nib))
        else $error("data result repeated or nibble-only");

    a_step_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == 3'd0))
        else $error("step not cleared after final result");

endmodule

// ----- hdl/char_lcd_text_sequencer_unit.sv -----
// Top level of the HD44780 character LCD text sequencer.
//
// Usage:
//   i_item  : text items (cmd, char_code), valid/ready. A transfer happens
//             when valid and ready are both high at a rising clock edge.
//   o_res   : bus results (reg_select, bus_byte, repeat_count, nibble_only,
//             last), valid/ready; last flags the final result of an item.
//   i_cfg_* : register writes, index 0 columns, index 1 rows. Write only
//             while no results are outstanding.
// Results: the first result of an item is registered in the job queue and
//   then in the result register. Each item yields 0 to 5 results (typically
//   1 for a character), one per cycle while o_res.ready is high; the back
//   end's single result register sets that rate. Items with no result
//   (dropped characters, command 3) never reach the back end.
// Stalls: a four-entry job queue sits between the cursor front end and the
//   result back end. While o_res.ready is low the front keeps taking items
//   until the queue fills, then drops i_item.ready.
// Reset (i_rst_n low, synchronous): cursor at 0,0, columns 16, rows 2,
//   queue empty, no result valid.
module char_lcd_text_sequencer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    clts_item_if.sink                  i_item,
    clts_res_if.source                 o_res,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [clts_pkg::CFG_W-1:0] i_cfg_data
);

    logic            push, pop, full, avail;
    clts_pkg::t_job  job_in, job_head;

    // front: cursor tracking and classification
    clts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job_in)
    );

    // decouples cursor updates from result delivery
    clts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_job   (job_head)
    );

    // back: per-job result sequencing into the output register
    clts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_job   (job_head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the character LCD text sequencer top level.
module testbench;

    // Command code 3 is not used by the block and must be ignored.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Watchdog limit; it leaves margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Cycles to let the front end settle once no result is outstanding.
    localparam int SETTLE_CYCLES = 8;

    // Minimum number of random text items to generate after the directed part.
    localparam int RANDOM_ITEMS = 70;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
    } t_text_item;

    typedef struct packed {
        logic                       reg_select;
        logic [7:0]                 data;
        logic [clts_pkg::CNT_W-1:0] count;
        logic                       nibble_only;
        logic                       last;
    } t_bus_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_idx = 1'b0;
    logic [clts_pkg::CFG_W-1:0] cfg_data = '0;

    clts_item_if item_if();
    clts_res_if  res_if();

    char_lcd_text_sequencer_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Text items waiting to be driven, and bus results still owed by the DUT.
    t_text_item pending_items[$];
    t_bus_res   bus_expected[$];

    // Shadow copy of the configuration and of the cursor.
    logic [clts_pkg::COL_W-1:0]  cfg_columns = clts_pkg::COLUMNS_RST;
    logic [clts_pkg::ROWS_W-1:0] cfg_rows    = clts_pkg::ROWS_RST;
    logic [clts_pkg::COL_W-1:0]  cur_col     = '0;
    logic [clts_pkg::ROW_W-1:0]  cur_row     = '0;

    int  errors = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    // When set, neither side idles: back-to-back transfers.
    logic steady = 1'b0;

    initial begin
        item_if.valid     = 1'b0;
        item_if.cmd       = clts_pkg::CMD_INIT;
        item_if.char_code = '0;
        res_if.ready      = 1'b0;
    end

    // Gap lengths: mostly zero or short, now and then a long one.
    function automatic int pick_gap(input int pct_zero);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_zero)
            return 0;
        if (r < pct_zero + (100 - pct_zero) * 7 / 10)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_bus_res mk_res(input logic rs, input logic [7:0] data,
                                        input int count, input logic nib);
        t_bus_res r;
        r.reg_select  = rs;
        r.data        = data;
        r.count       = count[clts_pkg::CNT_W-1:0];
        r.nibble_only = nib;
        r.last        = 1'b0;
        return r;
    endfunction

    // Move to column 0 of the next row: home, then the shift-right run.
    // Row saturates at its top value.
    function automatic int advance_row();
        int shifts;
        if (cur_row != '1)
            cur_row = cur_row + 1'b1;
        cur_col = '0;
        bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_HOME, 1, 1'b0));
        shifts = clts_pkg::ROW_STRIDE * int'(cur_row);
        if (shifts != 0) begin
            bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_SHIFT_RIGHT, shifts, 1'b0));
            return 2;
        end
        return 1;
    endfunction

    // Work out the bus results of one accepted text item and queue them.
    task automatic predict_bus(input logic [1:0] cmd, input logic [7:0] ch);
        int n;
        int nextcol;
        n = 0;
        case (cmd)
            clts_pkg::CMD_INIT: begin
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_MODE_NIBBLE, 1, 1'b1));
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_FUNCTION_SET, 1, 1'b0));
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_DISPLAY_ON, 1, 1'b0));
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_CLEAR, 1, 1'b0));
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_HOME, 1, 1'b0));
                n = 5;
                cur_col = '0;
                cur_row = '0;
            end
            clts_pkg::CMD_BEGIN: begin
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_CLEAR, 1, 1'b0));
                bus_expected.push_back(mk_res(1'b0, clts_pkg::OP_HOME, 1, 1'b0));
                n = 2;
                cur_col = '0;
                cur_row = '0;
            end
            clts_pkg::CMD_CHAR: begin
                if (ch == clts_pkg::CH_NEWLINE) begin
                    n = advance_row();
                end else if (int'(cur_row) < int'(cfg_rows)) begin
                    bus_expected.push_back(mk_res(1'b1, ch, 1, 1'b0));
                    n = 1;
                    nextcol = int'(cur_col) + 1;
                    // wraps also when columns was lowered below the cursor
                    if (nextcol >= int'(cfg_columns))
                        n += advance_row();
                    else
                        cur_col = nextcol[clts_pkg::COL_W-1:0];
                end
            end
            default: ;
        endcase
        if (n > 0)
            bus_expected[bus_expected.size() - 1].last = 1'b1;
    endtask

    function automatic void queue_item(input logic [1:0] cmd, input logic [7:0] ch);
        t_text_item it;
        it.cmd = cmd;
        it.ch  = ch;
        pending_items.push_back(it);
    endfunction

    // Driver: one item on the bus at a time, random gaps between transfers.
    // Prediction runs at the edge where the transfer happens.
    always @(posedge clk) begin : drive_items
        logic       nxt_valid;
        t_text_item nxt;
        nxt_valid = item_if.valid;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            send_gap  = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                predict_bus(item_if.cmd, item_if.char_code);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    item_if.cmd       <= nxt.cmd;
                    item_if.char_code <= nxt.ch;
                    nxt_valid = 1'b1;
                    send_gap  = steady ? 0 : pick_gap(55);
                end
            end
        end
        // single update per edge, so a held valid never dips
        item_if.valid <= nxt_valid;
    end

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            errors++;
        end
    endtask

    // Monitor: random back-pressure, and each result transfer is checked
    // against the oldest expectation.
    always @(posedge clk) begin : watch_results
        t_bus_res want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (bus_expected.size() == 0) begin
                    $error("unexpected result: bus_byte %0d", res_if.bus_byte);
                    errors++;
                end else begin
                    want = bus_expected.pop_front();
                    check_field("reg_select", int'(want.reg_select),
                                int'(res_if.reg_select));
                    check_field("bus_byte", int'(want.data), int'(res_if.bus_byte));
                    check_field("repeat_count", int'(want.count),
                                int'(res_if.repeat_count));
                    check_field("nibble_only", int'(want.nibble_only),
                                int'(res_if.nibble_only));
                    check_field("last", int'(want.last), int'(res_if.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                stall_left = steady ? 0 : pick_gap(70);
                res_if.ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Block until every queued item went out and every result came back,
    // then give dropped items still in the front end time to retire.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || item_if.valid || bus_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges. The rows write carries
    // random upper bits, which the block must ignore.
    task automatic write_config(input logic [clts_pkg::COL_W-1:0] cols,
                                input logic [clts_pkg::ROWS_W-1:0] rws);
        logic [2:0] junk;
        junk = 3'($urandom_range(0, 7));
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= clts_pkg::CFG_COLUMNS;
        cfg_data <= cols;
        @(posedge clk);
        cfg_idx  <= clts_pkg::CFG_ROWS;
        cfg_data <= {junk, rws};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_columns = cols;
        cfg_rows    = rws;
        @(negedge clk);
    endtask

    function automatic logic [clts_pkg::COL_W-1:0] pick_columns();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 6'd1;
            2: return '1;
            3: return 6'd40;
            4: return clts_pkg::COL_W'($urandom_range(1, 40));
            default: return clts_pkg::COL_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [clts_pkg::ROWS_W-1:0] pick_rows();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 3'd1;
            2: return '1;
            default: return clts_pkg::ROWS_W'($urandom_range(1, 4));
        endcase
    endfunction

    // One random text item, mostly characters.
    function automatic void queue_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72)
            queue_item(clts_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
        else if (r < 84)
            queue_item(clts_pkg::CMD_CHAR, clts_pkg::CH_NEWLINE);
        else if (r < 90)
            queue_item(clts_pkg::CMD_BEGIN, 8'($urandom_range(0, 255)));
        else if (r < 94)
            queue_item(clts_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
        else
            queue_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
    endfunction

    initial begin : stimulus
        int sent;
        int len;
        int r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset configuration (16 columns, 2 rows).
        queue_item(clts_pkg::CMD_INIT, 8'hFF);
        queue_item(clts_pkg::CMD_CHAR, 8'h00);
        queue_item(clts_pkg::CMD_CHAR, 8'hFF);
        queue_item(clts_pkg::CMD_CHAR, 8'h55);
        queue_item(clts_pkg::CMD_CHAR, clts_pkg::CH_NEWLINE);
        queue_item(clts_pkg::CMD_CHAR, 8'h41);
        queue_item(clts_pkg::CMD_CHAR, clts_pkg::CH_NEWLINE);  // now past the last row
        queue_item(clts_pkg::CMD_CHAR, 8'hAA);                 // dropped
        queue_item(clts_pkg::CMD_CHAR, clts_pkg::CH_NEWLINE);  // newline still goes out
        queue_item(CMD_UNUSED, 8'hFF);                         // ignored
        queue_item(CMD_UNUSED, 8'h00);
        queue_item(clts_pkg::CMD_BEGIN, 8'h00);

        // One column, one row: each character wraps, the next is dropped.
        write_config(6'd1, 3'd1);
        queue_item(clts_pkg::CMD_CHAR, 8'h61);
        queue_item(clts_pkg::CMD_CHAR, 8'h62);
        queue_item(clts_pkg::CMD_BEGIN, 8'h0A);

        // Zero columns: every sent character wraps.
        write_config('0, '1);
        queue_item(clts_pkg::CMD_CHAR, 8'h78);
        queue_item(clts_pkg::CMD_CHAR, 8'h79);

        // Zero rows: every printable character is dropped.
        write_config('1, '0);
        queue_item(clts_pkg::CMD_CHAR, 8'h7A);
        queue_item(clts_pkg::CMD_CHAR, clts_pkg::CH_NEWLINE);
        queue_item(clts_pkg::CMD_BEGIN, 8'hFF);

        // Walk the cursor right, then lower columns below it.
        write_config(6'd40, 3'd4);
        repeat (4) queue_item(clts_pkg::CMD_CHAR, 8'($urandom_range(32, 126)));
        write_config(6'd3, 3'd4);
        queue_item(clts_pkg::CMD_CHAR, 8'h7E);

        // Drive the row counter into saturation; characters along the way
        // past the last row are dropped.
        write_config(6'd40, '1);
        queue_item(clts_pkg::CMD_BEGIN, 8'h00);
        for (int i = 0; i < 258; i++) begin
            queue_item(clts_pkg::CMD_CHAR, clts_pkg::CH_NEWLINE);
            if (i % 37 == 0)
                queue_item(clts_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
        end
        queue_item(clts_pkg::CMD_CHAR, 8'h30);

        // Random phases: new settings each phase, mostly well-formed text
        // starting with begin-text, sometimes carrying the cursor over.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_config(pick_columns(), pick_rows());
            steady = ($urandom_range(0, 3) == 0);
            len = $urandom_range(12, 40);
            r = $urandom_range(0, 9);
            if (r < 7)
                queue_item(clts_pkg::CMD_BEGIN, 8'($urandom_range(0, 255)));
            else if (r < 8)
                queue_item(clts_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
            for (int i = 0; i < len; i++)
                queue_random_item();
            sent += len;
        end

        // Drain, then watch a while for stray results.
        wait_drained();
        repeat (20) @(posedge clk);
        if (bus_expected.size() != 0) begin
            $error("%0d expected results never arrived", bus_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
